FILE: hw/rtl/slcan_command_parser_core_defines.svh
// Assertion macros shared by the SLCAN parser checker.
// No dependencies; the using module must have clk and rst_n in scope.
`ifndef SLCAN_COMMAND_PARSER_CORE_DEFINES_SVH
`define SLCAN_COMMAND_PARSER_CORE_DEFINES_SVH

// Checked only outside reset.
`define SLCAN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SLCAN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/slcan_pkg.sv
// Package for the SLCAN command parser: result type, character and command codes,
// hex decode and bitrate table. No dependencies.
package slcan_pkg;

  localparam int MAX_LINE = 32;
  localparam int POS_W    = 6;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_OPEN   = 8'h4F; // O
  localparam logic [7:0] CH_CLOSE  = 8'h43; // C
  localparam logic [7:0] CH_LISTEN = 8'h4C; // L
  localparam logic [7:0] CH_SELF   = 8'h59; // Y
  localparam logic [7:0] CH_SETBR  = 8'h53; // S
  localparam logic [7:0] CH_STD    = 8'h74; // t
  localparam logic [7:0] CH_STDRTR = 8'h72; // r
  localparam logic [7:0] CH_EXT    = 8'h54; // T
  localparam logic [7:0] CH_EXTRTR = 8'h52; // R
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] KIND_OPEN    = 3'd0;
  localparam logic [2:0] KIND_CLOSE   = 3'd1;
  localparam logic [2:0] KIND_LISTEN  = 3'd2;
  localparam logic [2:0] KIND_SELF    = 3'd3;
  localparam logic [2:0] KIND_BITRATE = 3'd4;
  localparam logic [2:0] KIND_FRAME   = 3'd5;

  localparam logic [7:0]  CODE_DECIMAL = 8'hFF;
  localparam logic [31:0] STD_ID_MAX   = 32'h0000_07FF;

  typedef struct packed {
    logic        error;
    logic [2:0]  cmd_kind;
    logic [7:0]  rate_sel;
    logic [31:0] rate_value;
    logic [31:0] frame_id;
    logic        extended;
    logic        remote;
    logic [3:0]  frame_len;
    logic [63:0] payload;
  } res_t;

  // 0..15 for a hex digit in either case, 16 otherwise
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    return v;
  endfunction

  function automatic logic [31:0] rate_bps(input logic [3:0] idx);
    logic [31:0] r;
    case (idx)
      4'd0:    r = 32'd10000;
      4'd1:    r = 32'd20000;
      4'd2:    r = 32'd50000;
      4'd3:    r = 32'd100000;
      4'd4:    r = 32'd125000;
      4'd5:    r = 32'd250000;
      4'd6:    r = 32'd500000;
      4'd7:    r = 32'd800000;
      4'd8:    r = 32'd1000000;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/slcan_command_parser_core.sv
// SLCAN ASCII command parser, top level.
// Depends on slcan_pkg.
//
// Usage: one ASCII character per request on the in_ channel (in_valid/in_ready,
// in_char_in). A carriage return ends a command line and yields exactly one result
// on the out_ channel; all other characters yield none. Recognized lines: O, C, L,
// Y, S<n> / S<decimal>, and frames t/T/r/R with hex id, DLC and data digits.
// Malformed lines report out_error with every other field zero.
// Throughput: one character per cycle while in_ready is high, including back-to-back CRs.
// Result path: the per-line parse state updates in the accepting cycle; the
// result goes into the output register, or into the skid register behind it
// when the output register is full and not being drained.
// Stall: while out_ready is low the result holds; characters keep being taken
// until a second result is pending in the skid register, then in_ready drops
// until the output drains.
// Reset (rst_n low, synchronous): parse state cleared, both result registers
// emptied, in_ready high afterwards.
module slcan_command_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_error,
  output logic [2:0]  out_cmd_kind,
  output logic [7:0]  out_rate_sel,
  output logic [31:0] out_rate_value,
  output logic [31:0] out_frame_id,
  output logic        out_extended,
  output logic        out_remote,
  output logic [3:0]  out_frame_len,
  output logic [63:0] out_payload
);

  localparam int PW = slcan_pkg::POS_W;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    lead_r, lead_nxt;
  logic [7:0]    sec_r, sec_nxt;
  logic          bad_r, bad_nxt;
  logic [31:0]   id_r, id_nxt;
  logic [3:0]    len_r, len_nxt;
  logic [63:0]   data_r, data_nxt;
  logic [31:0]   dec_r, dec_nxt;

  slcan_pkg::res_t out_r, out_nxt, skd_r, skd_nxt, cr_res, ok_res;
  logic out_vld_r, out_vld_nxt, skd_vld_r, skd_vld_nxt;

  logic          acc, is_cr, push, pop;
  logic [4:0]    hv;
  logic [PW-1:0] q;
  logic          ok_k, ok_base;
  logic [PW-1:0] len2;

  assign in_ready = !skd_vld_r;
  assign acc      = in_valid && in_ready;
  assign is_cr    = (in_char_in == slcan_pkg::CH_CR);
  assign push     = acc && is_cr;
  assign pop      = out_vld_r && out_ready;
  assign hv       = slcan_pkg::hex_val(in_char_in);
  assign len2     = {1'b0, len_r, 1'b0};

  // per-character parse
  always_comb begin
    pos_nxt  = pos_r;
    lead_nxt = lead_r;
    sec_nxt  = sec_r;
    bad_nxt  = bad_r;
    id_nxt   = id_r;
    len_nxt  = len_r;
    data_nxt = data_r;
    dec_nxt  = dec_r;
    q        = '0;
    if (acc) begin
      if (is_cr) begin
        pos_nxt  = '0;
        lead_nxt = '0;
        sec_nxt  = '0;
        bad_nxt  = 1'b0;
        id_nxt   = '0;
        len_nxt  = '0;
        data_nxt = '0;
        dec_nxt  = '0;
      end else begin
        if (pos_r != {PW{1'b1}}) pos_nxt = pos_r + PW'(1);
        if (pos_r == '0) begin
          lead_nxt = in_char_in;
        end else begin
          if (pos_r == PW'(1)) sec_nxt = in_char_in;
          case (lead_r)
            slcan_pkg::CH_SETBR: begin
              if (in_char_in >= slcan_pkg::CH_ZERO && in_char_in <= slcan_pkg::CH_NINE)
                dec_nxt = (dec_r << 3) + (dec_r << 1) + {28'd0, in_char_in[3:0]};
              else
                bad_nxt = 1'b1;
            end
            slcan_pkg::CH_STD, slcan_pkg::CH_STDRTR,
            slcan_pkg::CH_EXT, slcan_pkg::CH_EXTRTR: begin
              // id digits, then DLC, then data nibbles (high nibble first)
              if ((lead_r == slcan_pkg::CH_STD || lead_r == slcan_pkg::CH_STDRTR)
                  ? (pos_r <= PW'(3)) : (pos_r <= PW'(8))) begin
                if (hv[4]) bad_nxt = 1'b1;
                else id_nxt = {id_r[27:0], hv[3:0]};
              end else if ((lead_r == slcan_pkg::CH_STD || lead_r == slcan_pkg::CH_STDRTR)
                           ? (pos_r == PW'(4)) : (pos_r == PW'(9))) begin
                if (hv > 5'd8) bad_nxt = 1'b1;
                else len_nxt = hv[3:0];
              end else begin
                q = (lead_r == slcan_pkg::CH_STD || lead_r == slcan_pkg::CH_STDRTR)
                    ? pos_r - PW'(5) : pos_r - PW'(10);
                if (hv[4]) bad_nxt = 1'b1;
                else if (q[5:4] == 2'b00)
                  data_nxt[{q[3:1], ~q[0], 2'b00} +: 4] = hv[3:0];
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // result for a CR arriving now
  always_comb begin
    ok_res  = '0;
    ok_k    = 1'b1;
    ok_base = !bad_r && (pos_r < PW'(slcan_pkg::MAX_LINE));
    case (lead_r)
      slcan_pkg::CH_OPEN: begin
        ok_res.cmd_kind = slcan_pkg::KIND_OPEN;
        ok_k = (pos_r == PW'(1));
      end
      slcan_pkg::CH_CLOSE: begin
        ok_res.cmd_kind = slcan_pkg::KIND_CLOSE;
        ok_k = (pos_r == PW'(1));
      end
      slcan_pkg::CH_LISTEN: begin
        ok_res.cmd_kind = slcan_pkg::KIND_LISTEN;
        ok_k = (pos_r == PW'(1));
      end
      slcan_pkg::CH_SELF: begin
        ok_res.cmd_kind = slcan_pkg::KIND_SELF;
        ok_k = (pos_r == PW'(1));
      end
      slcan_pkg::CH_SETBR: begin
        ok_res.cmd_kind = slcan_pkg::KIND_BITRATE;
        if (pos_r == PW'(2) && sec_r >= slcan_pkg::CH_ZERO && sec_r <= slcan_pkg::CH_EIGHT)
        begin
          ok_res.rate_sel   = sec_r - slcan_pkg::CH_ZERO;
          ok_res.rate_value = slcan_pkg::rate_bps(sec_r[3:0]);
        end else if (pos_r >= PW'(2)) begin
          ok_res.rate_sel   = slcan_pkg::CODE_DECIMAL;
          ok_res.rate_value = dec_r;
        end else begin
          ok_k = 1'b0;
        end
      end
      slcan_pkg::CH_STD: begin
        ok_k = (pos_r == PW'(5) + len2) && (id_r <= slcan_pkg::STD_ID_MAX);
        ok_res.cmd_kind  = slcan_pkg::KIND_FRAME;
        ok_res.frame_id  = id_r;
        ok_res.frame_len = len_r;
        ok_res.payload   = data_r;
      end
      slcan_pkg::CH_STDRTR: begin
        ok_k = (pos_r == PW'(5)) && (id_r <= slcan_pkg::STD_ID_MAX);
        ok_res.cmd_kind  = slcan_pkg::KIND_FRAME;
        ok_res.frame_id  = id_r;
        ok_res.frame_len = len_r;
        ok_res.remote    = 1'b1;
      end
      slcan_pkg::CH_EXT: begin
        ok_k = (pos_r == PW'(10) + len2);
        ok_res.cmd_kind  = slcan_pkg::KIND_FRAME;
        ok_res.frame_id  = id_r;
        ok_res.frame_len = len_r;
        ok_res.extended  = 1'b1;
        ok_res.payload   = data_r;
      end
      slcan_pkg::CH_EXTRTR: begin
        ok_k = (pos_r == PW'(10));
        ok_res.cmd_kind  = slcan_pkg::KIND_FRAME;
        ok_res.frame_id  = id_r;
        ok_res.frame_len = len_r;
        ok_res.extended  = 1'b1;
        ok_res.remote    = 1'b1;
      end
      default: ok_k = 1'b0;
    endcase
    if (ok_base && ok_k) begin
      cr_res = ok_res;
    end else begin
      cr_res       = '0;
      cr_res.error = 1'b1;
    end
  end

  // output register plus skid register
  always_comb begin
    out_nxt     = out_r;
    skd_nxt     = skd_r;
    out_vld_nxt = out_vld_r;
    skd_vld_nxt = skd_vld_r;
    if (skd_vld_r) begin
      if (pop) begin
        out_nxt     = skd_r;
        skd_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_nxt     = cr_res;
        out_vld_nxt = 1'b1;
      end else begin
        skd_nxt     = cr_res;
        skd_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      lead_r    <= '0;
      sec_r     <= '0;
      bad_r     <= 1'b0;
      id_r      <= '0;
      len_r     <= '0;
      data_r    <= '0;
      dec_r     <= '0;
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      lead_r    <= lead_nxt;
      sec_r     <= sec_nxt;
      bad_r     <= bad_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      data_r    <= data_nxt;
      dec_r     <= dec_nxt;
      out_vld_r <= out_vld_nxt;
      skd_vld_r <= skd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    skd_r <= skd_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_error      = out_r.error;
  assign out_cmd_kind   = out_r.cmd_kind;
  assign out_rate_sel   = out_r.rate_sel;
  assign out_rate_value = out_r.rate_value;
  assign out_frame_id   = out_r.frame_id;
  assign out_extended   = out_r.extended;
  assign out_remote     = out_r.remote;
  assign out_frame_len  = out_r.frame_len;
  assign out_payload    = out_r.payload;

endmodule

FILE: hw/rtl/slcan_chk.sv
// Port-level checker for the SLCAN command parser, bound to the top level.
// Depends on slcan_pkg and slcan_command_parser_core_defines.svh.
`include "slcan_command_parser_core_defines.svh"

module slcan_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_error,
  input logic [2:0]  out_cmd_kind,
  input logic [7:0]  out_rate_sel,
  input logic [31:0] out_rate_value,
  input logic [31:0] out_frame_id,
  input logic        out_extended,
  input logic        out_remote,
  input logic [3:0]  out_frame_len,
  input logic [63:0] out_payload
);

  logic         res_ok;
  logic         frame_zero;
  logic         rest_zero;
  logic [145:0] res_bits;

  assign res_ok     = out_valid && !out_error;
  assign frame_zero = out_frame_id == '0 && out_payload == '0 && out_frame_len == '0
                      && !out_extended && !out_remote;
  assign rest_zero  = frame_zero && out_rate_sel == '0 && out_rate_value == '0;
  assign res_bits   = {out_error, out_cmd_kind, out_rate_sel, out_rate_value, out_frame_id,
                       out_extended, out_remote, out_frame_len, out_payload};

  `SLCAN_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid && in_ready, "result after reset")

  `SLCAN_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(res_bits), "held")

  `SLCAN_ASSERT(a_err_zero, out_valid && out_error |-> out_cmd_kind == '0 && rest_zero, "err")

  `SLCAN_ASSERT(a_frame_fields, res_ok && out_cmd_kind != slcan_pkg::KIND_FRAME |-> frame_zero, "frm")

  `SLCAN_ASSERT(a_frame_len, res_ok |-> out_frame_len <= 4'd8 && (!out_remote || out_payload == '0), "len")

endmodule

bind slcan_command_parser_core slcan_chk u_slcan_chk (.*);

FILE: tb/slcan_command_parser_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for slcan_command_parser_core: directed command lines, then
// random SLCAN lines, with a built-in line parser predicting each result.
// Depends on slcan_pkg and the parser RTL.
module slcan_command_parser_core_tb;

  localparam int RANDOM_CHARS = 1470;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 8;
  localparam int NUM_PINNED   = 32;
  localparam int MAX_PRINTS   = 40;

  // S0..S8 rates, index 8 leftmost
  localparam logic [8:0][31:0] BPS_TABLE = {
    32'd1000000, 32'd800000, 32'd500000, 32'd250000, 32'd125000,
    32'd100000, 32'd50000, 32'd20000, 32'd10000
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_in = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_error;
  logic [2:0]  out_cmd_kind;
  logic [7:0]  out_rate_sel;
  logic [31:0] out_rate_value;
  logic [31:0] out_frame_id;
  logic        out_extended;
  logic        out_remote;
  logic [3:0]  out_frame_len;
  logic [63:0] out_payload;

  slcan_command_parser_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_error      (out_error),
    .out_cmd_kind   (out_cmd_kind),
    .out_rate_sel   (out_rate_sel),
    .out_rate_value (out_rate_value),
    .out_frame_id   (out_frame_id),
    .out_extended   (out_extended),
    .out_remote     (out_remote),
    .out_frame_len  (out_frame_len),
    .out_payload    (out_payload)
  );

  always #1 clk = ~clk;

  // line parser state
  logic [5:0]  line_len = '0;
  logic [7:0]  first_ch = '0;
  logic [7:0]  second_ch = '0;
  logic        line_bad = 1'b0;
  logic [31:0] id_acc = '0;
  logic [3:0]  dlc_acc = '0;
  logic [63:0] data_acc = '0;
  logic [31:0] dec_acc = '0;

  slcan_pkg::res_t pending_replies[$];
  logic [7:0]      line_buf[$];
  string           row_text[$];
  slcan_pkg::res_t pinned_res [NUM_PINNED];
  bit              pinned_on [NUM_PINNED];

  int fail_count = 0;
  int lines_done = 0;
  int idle_cycles = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  int stall_left = 0;
  bit hold_req = 1'b0;

  task automatic report_fail(input string msg);
    if (fail_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_fail($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;  // fold letters to lower case
    if (c >= slcan_pkg::CH_ZERO && c <= slcan_pkg::CH_NINE) return {1'b0, c[3:0]};
    if (folded >= 8'h61 && folded <= 8'h66) return 5'(folded - 8'h57);
    return 5'd16;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return slcan_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic slcan_pkg::res_t simple_res(input logic [2:0] kind,
                                                 input logic [7:0] code,
                                                 input logic [31:0] bps);
    slcan_pkg::res_t r;
    r = '0;
    r.cmd_kind = kind;
    r.rate_sel = code;
    r.rate_value = bps;
    return r;
  endfunction

  function automatic slcan_pkg::res_t failed_res();
    slcan_pkg::res_t r;
    r = '0;
    r.error = 1'b1;
    return r;
  endfunction

  // id digits below dlc_pos, then the DLC, then data nibbles (high nibble first)
  task automatic take_frame_char(input int p, input int dlc_pos, input logic [7:0] c);
    logic [4:0] nib;
    int q;
    nib = nibble_of(c);
    q = p - dlc_pos - 1;
    if (p < dlc_pos) begin
      if (nib[4]) line_bad = 1'b1;
      else id_acc = {id_acc[27:0], nib[3:0]};
    end else if (p == dlc_pos) begin
      if (nib > 5'd8) line_bad = 1'b1;
      else dlc_acc = nib[3:0];
    end else if (nib[4]) begin
      line_bad = 1'b1;
    end else if (q < 16) begin
      data_acc |= 64'(nib[3:0]) << (8 * (q / 2) + ((q % 2 == 0) ? 4 : 0));
    end
  endtask

  task automatic step_parser(input logic [7:0] c, output bit produced,
                             output slcan_pkg::res_t r);
    int p;
    bit good;
    p = int'(line_len);
    produced = 1'b0;
    r = '0;
    if (c != slcan_pkg::CH_CR) begin
      if (p == 0) begin
        first_ch = c;
      end else begin
        if (p == 1) second_ch = c;
        case (first_ch)
          slcan_pkg::CH_SETBR: begin
            if (c >= slcan_pkg::CH_ZERO && c <= slcan_pkg::CH_NINE)
              dec_acc = dec_acc * 32'd10 + 32'(c - slcan_pkg::CH_ZERO);
            else
              line_bad = 1'b1;
          end
          slcan_pkg::CH_STD, slcan_pkg::CH_STDRTR: take_frame_char(p, 4, c);
          slcan_pkg::CH_EXT, slcan_pkg::CH_EXTRTR: take_frame_char(p, 9, c);
          default: ;
        endcase
      end
      if (line_len != 6'd63) line_len = line_len + 6'd1;
    end else begin
      produced = 1'b1;
      good = !line_bad && (p < slcan_pkg::MAX_LINE);
      if (good) begin
        case (first_ch)
          slcan_pkg::CH_OPEN: begin
            r.cmd_kind = slcan_pkg::KIND_OPEN;
            good = (p == 1);
          end
          slcan_pkg::CH_CLOSE: begin
            r.cmd_kind = slcan_pkg::KIND_CLOSE;
            good = (p == 1);
          end
          slcan_pkg::CH_LISTEN: begin
            r.cmd_kind = slcan_pkg::KIND_LISTEN;
            good = (p == 1);
          end
          slcan_pkg::CH_SELF: begin
            r.cmd_kind = slcan_pkg::KIND_SELF;
            good = (p == 1);
          end
          slcan_pkg::CH_SETBR: begin
            r.cmd_kind = slcan_pkg::KIND_BITRATE;
            if (p == 2 && second_ch >= slcan_pkg::CH_ZERO
                && second_ch <= slcan_pkg::CH_EIGHT) begin
              r.rate_sel = second_ch - slcan_pkg::CH_ZERO;
              r.rate_value = BPS_TABLE[second_ch[3:0]];
            end else if (p >= 2) begin
              r.rate_sel = slcan_pkg::CODE_DECIMAL;
              r.rate_value = dec_acc;
            end else begin
              good = 1'b0;
            end
          end
          slcan_pkg::CH_STD, slcan_pkg::CH_STDRTR: begin
            r.cmd_kind = slcan_pkg::KIND_FRAME;
            r.frame_id = id_acc;
            r.frame_len = dlc_acc;
            r.remote = (first_ch == slcan_pkg::CH_STDRTR);
            r.payload = r.remote ? 64'd0 : data_acc;
            good = (p == (r.remote ? 5 : 5 + 2 * int'(dlc_acc)))
                   && (id_acc <= slcan_pkg::STD_ID_MAX);
          end
          slcan_pkg::CH_EXT, slcan_pkg::CH_EXTRTR: begin
            r.cmd_kind = slcan_pkg::KIND_FRAME;
            r.frame_id = id_acc;
            r.frame_len = dlc_acc;
            r.extended = 1'b1;
            r.remote = (first_ch == slcan_pkg::CH_EXTRTR);
            r.payload = r.remote ? 64'd0 : data_acc;
            good = (p == (r.remote ? 10 : 10 + 2 * int'(dlc_acc)));
          end
          default: good = 1'b0;
        endcase
      end
      if (!good) r = failed_res();
      line_len = '0;
      first_ch = '0;
      second_ch = '0;
      line_bad = 1'b0;
      id_acc = '0;
      dlc_acc = '0;
      data_acc = '0;
      dec_acc = '0;
    end
  endtask

  // mostly no gap, a few short ones, rarely long; occasional calm stretches
  task automatic pick_gap(inout int calm, output int n);
    int roll;
    n = 0;
    if (calm > 0) begin
      calm--;
      return;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) calm = $urandom_range(20, 80);
    else if (roll < 70) n = 0;
    else if (roll < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c);
    int n;
    pick_gap(tx_calm, n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input string s, input bit pin, input slcan_pkg::res_t r);
    row_text.push_back(s);
    if (pin) begin
      pinned_on[row_text.size() - 1] = 1'b1;
      pinned_res[row_text.size() - 1] = r;
    end
  endtask

  // one random line into line_buf, CR included
  task automatic build_line();
    int kind;
    int pos;
    int n;
    bit ext;
    bit rtr;
    logic [3:0] dlc;
    logic [7:0] lead;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      case ($urandom_range(0, 3))
        0: line_buf.push_back(slcan_pkg::CH_OPEN);
        1: line_buf.push_back(slcan_pkg::CH_CLOSE);
        2: line_buf.push_back(slcan_pkg::CH_LISTEN);
        default: line_buf.push_back(slcan_pkg::CH_SELF);
      endcase
    end else if (kind < 22) begin
      line_buf.push_back(slcan_pkg::CH_SETBR);
      n = $urandom_range(0, 1) ? 1 : $urandom_range(1, 14);
      repeat (n) line_buf.push_back(slcan_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (kind < 80) begin
      ext = $urandom_range(0, 1);
      rtr = ($urandom_range(0, 3) == 0);
      if (ext) line_buf.push_back(rtr ? slcan_pkg::CH_EXTRTR : slcan_pkg::CH_EXT);
      else line_buf.push_back(rtr ? slcan_pkg::CH_STDRTR : slcan_pkg::CH_STD);
      if (ext) begin
        repeat (8) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      end else begin
        // keep most standard ids in range
        line_buf.push_back(hex_char(4'($urandom_range(0,
                                      ($urandom_range(0, 9) == 0) ? 15 : 7))));
        repeat (2) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      if ($urandom_range(0, 11) == 0) begin
        line_buf.push_back($urandom_range(0, 1) ? hex_char(4'($urandom_range(9, 15)))
                                                : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 16)) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      end else begin
        dlc = 4'($urandom_range(0, 8));
        line_buf.push_back(hex_char(dlc));
        if (!rtr) repeat (2 * dlc) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      end
    end else if (kind < 90) begin
      repeat ($urandom_range(0, 40)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      // lengths around the line limit
      case ($urandom_range(0, 2))
        0: lead = slcan_pkg::CH_SETBR;
        1: lead = slcan_pkg::CH_STD;
        default: lead = slcan_pkg::CH_EXT;
      endcase
      line_buf.push_back(lead);
      repeat ($urandom_range(slcan_pkg::MAX_LINE - 6, slcan_pkg::MAX_LINE + 6))
        line_buf.push_back((lead == slcan_pkg::CH_SETBR)
                           ? slcan_pkg::CH_ZERO + 8'($urandom_range(0, 9))
                           : hex_char(4'($urandom_range(0, 15))));
    end
    if (kind < 80 && line_buf.size() > 0 && $urandom_range(0, 7) == 0) begin
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: line_buf[pos] = 8'($urandom_range(0, 255));
        1: line_buf.delete(pos);
        default: line_buf.insert(pos, hex_char(4'($urandom_range(0, 15))));
      endcase
    end
    line_buf.push_back(slcan_pkg::CH_CR);
  endtask

  // accepted requests feed the parser; accepted results are checked in order
  always @(posedge clk) begin : scoreboard
    slcan_pkg::res_t predicted;
    slcan_pkg::res_t want;
    bit produced;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        step_parser(in_char_in, produced, predicted);
        if (produced) begin
          if (lines_done < NUM_PINNED && pinned_on[lines_done])
            predicted = pinned_res[lines_done];
          pending_replies.push_back(predicted);
          lines_done++;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          report_fail("result with no command line pending");
        end else begin
          want = pending_replies.pop_front();
          check_field("error", out_error, want.error);
          check_field("cmd_kind", out_cmd_kind, want.cmd_kind);
          check_field("rate_sel", out_rate_sel, want.rate_sel);
          check_field("rate_value", out_rate_value, want.rate_value);
          check_field("frame_id", out_frame_id, want.frame_id);
          check_field("extended", out_extended, want.extended);
          check_field("remote", out_remote, want.remote);
          check_field("frame_len", out_frame_len, want.frame_len);
          check_field("payload", out_payload, want.payload);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : drain
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        pick_gap(rx_calm, n);
        stall_left = n;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    string s;
    string long_ok;
    string long_bad;
    string way_long;
    int sent;
    int lines;
    long_ok = "S";
    repeat (30) long_ok = {long_ok, "0"};
    long_bad = {long_ok, "0"};
    way_long = "S";
    repeat (40) way_long = {way_long, "7"};

    add_row("O", 1, simple_res(slcan_pkg::KIND_OPEN, 8'd0, 32'd0));
    add_row("C", 1, simple_res(slcan_pkg::KIND_CLOSE, 8'd0, 32'd0));
    add_row("L", 1, simple_res(slcan_pkg::KIND_LISTEN, 8'd0, 32'd0));
    add_row("Y", 1, simple_res(slcan_pkg::KIND_SELF, 8'd0, 32'd0));
    add_row("", 1, failed_res());
    add_row("O1", 1, failed_res());
    add_row("Q", 1, failed_res());
    add_row("S0", 1, simple_res(slcan_pkg::KIND_BITRATE, 8'd0, 32'd10000));
    add_row("S8", 1, simple_res(slcan_pkg::KIND_BITRATE, 8'd8, 32'd1000000));
    add_row("S9", 1, simple_res(slcan_pkg::KIND_BITRATE, slcan_pkg::CODE_DECIMAL, 32'd9));
    add_row("S", 1, failed_res());
    add_row("S12x", 1, failed_res());
    add_row("S4294967296", 0, '0);
    add_row(long_ok, 1, simple_res(slcan_pkg::KIND_BITRATE, slcan_pkg::CODE_DECIMAL, 32'd0));
    add_row(long_bad, 1, failed_res());
    add_row(way_long, 1, failed_res());
    add_row("t7FF8FFFFFFFFFFFFFFFF", 0, '0);
    add_row("t0000", 0, '0);
    add_row("t8000", 1, failed_res());
    add_row("t7ab2aBcD", 0, '0);
    add_row("t12310", 1, failed_res());
    add_row("t123g", 1, failed_res());
    add_row("r1234", 0, '0);
    add_row("r12300", 1, failed_res());
    add_row("TFFFFFFFF8ffffffffffffffff", 0, '0);
    add_row("T000000000", 0, '0);
    add_row("R1FFFFFFF8", 0, '0);
    add_row("R12345678F", 1, failed_res());
    add_row("O\001", 1, failed_res());

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (row_text[i]) begin
      s = row_text[i];
      for (int k = 0; k < s.len(); k++) send_char(s[k]);
      send_char(slcan_pkg::CH_CR);
    end

    // long result stall while requests keep coming
    hold_req = 1'b1;
    sent = 0;
    lines = 0;
    while (sent < RANDOM_CHARS) begin
      if (lines == 60) begin
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge clk);
      end
      build_line();
      sent += line_buf.size();
      lines++;
      while (line_buf.size() != 0) send_char(line_buf.pop_front());
    end

    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/slcan_pkg.sv
hw/rtl/slcan_command_parser_core.sv
hw/rtl/slcan_chk.sv
tb/slcan_command_parser_core_tb.sv
